// ----- rtl/lru_key_value_cache_assert.svh -----
// assertion macros for the lru key/value cache
// no dependencies; included by the cache top level, which carries the assertions
`ifndef LRU_KEY_VALUE_CACHE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_ASSERT_SVH

// same-cycle implication, disabled while reset is high
`define LKVC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lkvc same-cycle check failed");

// next-cycle implication, disabled while reset is high
`define LKVC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lkvc next-cycle check failed");

`endif

// ----- rtl/lkvc_pkg.sv -----
// shared types and constants of the lru key/value cache
// no dependencies; imported by the cache top level
package lkvc_pkg;

   localparam int KEY_SPACE  = 1024;
   localparam int KEY_BITS   = $clog2(KEY_SPACE);
   localparam int VALUE_BITS = 31;
   localparam int OCC_BITS   = $clog2(KEY_SPACE + 1);
   localparam int CAP_BITS   = 11;

   typedef logic [KEY_BITS-1:0]   key_type;
   typedef logic [VALUE_BITS-1:0] value_type;
   typedef logic [OCC_BITS-1:0]   occ_type;
   typedef logic [CAP_BITS-1:0]   cap_type;

   localparam cap_type CAP_RESET = CAP_BITS'(KEY_SPACE);
   localparam key_type KEY_LAST  = KEY_BITS'(KEY_SPACE - 1);

   // command codes
   localparam logic CMD_GET = 1'b0;
   localparam logic CMD_PUT = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECIDE,
      ST_LINK,
      ST_EVICT_RD,
      ST_EVICT_WB
   } state_type;

endpackage

// ----- rtl/lkvc_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies; instantiated for every store of the cache
module lkvc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/lru_key_value_cache.sv -----
// lru key/value cache: sequencer, list pointers and the four stores
// depends on lkvc_pkg, lkvc_ram and lru_key_value_cache_assert.svh
//
// channel   ports                                    transfer
// request   start, busy, req_command/key/value      start high while busy low
// result    rsp_strobe, rsp_found, rsp_read_value   one cycle, strobe high
// config    csr_valid, csr_ready, csr_wdata         valid and ready high
//
// each item is handled in the decide state; a present key that is not the most
// recent then passes through the link state, and an insert that exceeds the
// capacity through the evict-read and, while keys remain, evict-write states.
// the link stores have a single write port each, so a relink unlinks in decide
// and splices in link, and eviction needs a read-after-write of the newer link.
// after reset the present store is cleared one entry a cycle: busy stays high
// until every entry is cleared; config writes are taken meanwhile.
// a get result appears in the cycle after its decision cycle; puts give none.
`include "lru_key_value_cache_assert.svh"

module lru_key_value_cache (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_command,
   input  logic [lkvc_pkg::KEY_BITS-1:0]     req_key,
   input  logic [lkvc_pkg::VALUE_BITS-1:0]   req_value,
   output logic                              rsp_strobe,
   output logic                              rsp_found,
   output logic [lkvc_pkg::VALUE_BITS-1:0]   rsp_read_value,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lkvc_pkg::CAP_BITS-1:0]     csr_wdata
);

   import lkvc_pkg::*;

   state_type state_ff, state_in;
   key_type   mru_ff, mru_in;
   key_type   lru_ff, lru_in;
   occ_type   occ_ff, occ_in;
   occ_type   occ_inc;
   key_type   clr_cnt_ff, clr_cnt_in;
   cap_type   cap_ff;

   logic      cmd_ff;
   key_type   key_ff;
   value_type value_ff;

   logic      rsp_strobe_ff, rsp_strobe_in;
   logic      rsp_found_ff, rsp_found_in;
   value_type rsp_value_ff, rsp_value_in;

   // memory ports
   logic      pres_we, pres_wd, pres_rd;
   key_type   pres_wa;
   logic      val_we;
   value_type val_rd;
   logic      old_we;
   key_type   old_wa, old_wd, old_rd;
   logic      new_we;
   key_type   new_wa, new_wd, new_ra, new_rd;

   logic      accept;

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign occ_inc   = occ_ff + OCC_BITS'(1);

   // stores
   lkvc_ram #(.WIDTH(1), .DEPTH(KEY_SPACE)) u_pres_ram (
      .clock   (clock),
      .wr_en   (pres_we),
      .wr_addr (pres_wa),
      .wr_data (pres_wd),
      .rd_addr (req_key),
      .rd_data (pres_rd)
   );

   lkvc_ram #(.WIDTH(VALUE_BITS), .DEPTH(KEY_SPACE)) u_val_ram (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (key_ff),
      .wr_data (value_ff),
      .rd_addr (req_key),
      .rd_data (val_rd)
   );

   lkvc_ram #(.WIDTH(KEY_BITS), .DEPTH(KEY_SPACE)) u_older_ram (
      .clock   (clock),
      .wr_en   (old_we),
      .wr_addr (old_wa),
      .wr_data (old_wd),
      .rd_addr (req_key),
      .rd_data (old_rd)
   );

   lkvc_ram #(.WIDTH(KEY_BITS), .DEPTH(KEY_SPACE)) u_newer_ram (
      .clock   (clock),
      .wr_en   (new_we),
      .wr_addr (new_wa),
      .wr_data (new_wd),
      .rd_addr (new_ra),
      .rd_data (new_rd)
   );

   // state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         mru_ff        <= '0;
         lru_ff        <= '0;
         occ_ff        <= '0;
         clr_cnt_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mru_ff        <= mru_in;
         lru_ff        <= lru_in;
         occ_ff        <= occ_in;
         clr_cnt_ff    <= clr_cnt_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_valid && csr_ready) begin
         cap_ff <= csr_wdata;
      end
   end

   // request capture and result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= req_command;
         key_ff   <= req_key;
         value_ff <= req_value;
      end
      rsp_found_ff <= rsp_found_in;
      rsp_value_ff <= rsp_value_in;
   end

   // sequencer: next state, list pointers and memory writes
   always_comb begin
      state_in      = state_ff;
      mru_in        = mru_ff;
      lru_in        = lru_ff;
      occ_in        = occ_ff;
      clr_cnt_in    = clr_cnt_ff;
      rsp_strobe_in = 1'b0;
      rsp_found_in  = rsp_found_ff;
      rsp_value_in  = rsp_value_ff;
      pres_we       = 1'b0;
      pres_wa       = key_ff;
      pres_wd       = 1'b0;
      val_we        = 1'b0;
      old_we        = 1'b0;
      old_wa        = key_ff;
      old_wd        = mru_ff;
      new_we        = 1'b0;
      new_wa        = mru_ff;
      new_wd        = key_ff;
      new_ra        = req_key;

      unique case (state_ff)
         ST_CLEAR: begin
            // sweep the present store to zero
            pres_we    = 1'b1;
            pres_wa    = clr_cnt_ff;
            clr_cnt_in = clr_cnt_ff + KEY_BITS'(1);
            if (clr_cnt_ff == KEY_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            // get result from the lookup
            if (cmd_ff == CMD_GET) begin
               rsp_strobe_in = 1'b1;
               rsp_found_in  = pres_rd;
               rsp_value_in  = pres_rd ? val_rd : '0;
            end
            val_we = (cmd_ff == CMD_PUT);
            if (pres_rd) begin
               // unlink a present key unless it is already most recent
               if (key_ff != mru_ff) begin
                  if (key_ff == lru_ff) begin
                     lru_in = new_rd;
                  end else begin
                     new_we = 1'b1;
                     new_wa = old_rd;
                     new_wd = new_rd;
                     old_we = 1'b1;
                     old_wa = new_rd;
                     old_wd = old_rd;
                  end
                  state_in = ST_LINK;
               end else begin
                  state_in = ST_IDLE;
               end
            end else if (cmd_ff == CMD_PUT) begin
               // insert at the most recent end
               pres_we = 1'b1;
               pres_wd = 1'b1;
               if (occ_ff == '0) begin
                  lru_in = key_ff;
               end else begin
                  old_we = 1'b1;
                  new_we = 1'b1;
               end
               mru_in = key_ff;
               occ_in = occ_inc;
               if (occ_inc > cap_ff) begin
                  state_in = ST_EVICT_RD;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_LINK: begin
            // splice the key in front of the old most recent key
            old_we   = 1'b1;
            new_we   = 1'b1;
            mru_in   = key_ff;
            state_in = ST_IDLE;
         end
         ST_EVICT_RD: begin
            // drop the least recent key, fetch its newer neighbor
            pres_we = 1'b1;
            pres_wa = lru_ff;
            new_ra  = lru_ff;
            occ_in  = occ_ff - OCC_BITS'(1);
            if (occ_ff > OCC_BITS'(1)) begin
               state_in = ST_EVICT_WB;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EVICT_WB: begin
            lru_in   = new_rd;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_read_value = rsp_value_ff;

   // checks
   `LKVC_ASSERT_NEXT(a_accept_decides, clock, reset, accept, state_ff == ST_DECIDE)
   `LKVC_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_strobe_ff, !rsp_strobe_ff)
   `LKVC_ASSERT_NOW(a_occ_bound, clock, reset, 1'b1, occ_ff <= OCC_BITS'(KEY_SPACE))
   `LKVC_ASSERT_NOW(a_miss_zero, clock, reset, rsp_strobe_ff && !rsp_found_ff, rsp_value_ff == '0)
   `LKVC_ASSERT_NOW(a_evict_order, clock, reset, state_ff == ST_EVICT_WB, $past(state_ff) == ST_EVICT_RD)

endmodule
